FILE: hw/rtl/ssud_pkg.sv
// Package: word types for the selection sorter.
`timescale 1ns / 1ps
`default_nettype none
package ssud_pkg;

    localparam int unsigned DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_in;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

endpackage
`default_nettype wire

FILE: hw/rtl/selection_sort_up_down.sv
// Top level: list buffer and selection sort sequencer around the element store.
//
//  channel  | signals                                 | handshake
//  ---------+-----------------------------------------+---------------------------
//  input    | i_in (value, last_in)                   | taken when start & !busy
//  result   | o_out (sorted_value, last_out, overflow)| one cycle, o_out_strobe
//  config   | i_cfg_data (descending)                 | taken when valid & ready
//
// Loading takes a word whenever start is high and busy is low. The word with last_in
// starts the sort; each pass reads the m remaining entries through the single store
// read port, and a list of n words is emitted one word per pass. Busy stays
// high until the last pass ends, so the last word comes out with busy already low.
// Reset (synchronous, active low) clears the count, drop flag and mode; the
// store keeps its contents. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module selection_sort_up_down #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire ssud_pkg::t_in_word i_in,
    output logic                 o_out_strobe,
    output ssud_pkg::t_out_word  o_out,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire                  i_cfg_data
);
    import ssud_pkg::*;

    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_drop, n_drop;
    logic                 r_desc;
    logic [CW-1:0]        r_n, n_n;
    logic [AW-1:0]        r_pos, n_pos;
    logic [AW-1:0]        r_last_idx, n_last_idx;
    logic [CW-1:0]        r_rd_addr, n_rd_addr;
    logic                 r_rd_vld;
    logic [AW-1:0]        r_rd_idx;
    logic signed [DATA_W-1:0] r_best, n_best;
    logic signed [DATA_W-1:0] r_first, n_first;
    logic [AW-1:0]        r_pick, n_pick;
    logic                 r_strobe, n_strobe;
    t_out_word            r_out, n_out;

    logic                 accept;
    logic                 rd_en;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic signed [DATA_W-1:0] rd_data;
    logic                 better;

    assign busy         = (r_state != S_IDLE);
    assign accept       = start && (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_strobe = r_strobe;
    assign o_out        = r_out;

    assign rd_en  = (r_state == S_SCAN) && (r_rd_addr < r_n);
    assign better = r_desc ? (rd_data > r_best) : (rd_data < r_best);

    ssud_mem #(
        .DEPTH (MAX_ITEMS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_rd_addr[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_drop     = r_drop;
        n_n        = r_n;
        n_pos      = r_pos;
        n_last_idx = r_last_idx;
        n_rd_addr  = r_rd_addr;
        n_best     = r_best;
        n_first    = r_first;
        n_pick     = r_pick;
        n_strobe   = 1'b0;
        n_out      = r_out;
        we         = 1'b0;
        waddr      = r_count[AW-1:0];
        wdata      = i_in.value;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_count < CW'(MAX_ITEMS)) begin
                        // store the word at the next free entry
                        we      = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_in.last_in) begin
                        n_n        = n_count;
                        n_last_idx = AW'(n_count - 1'b1);
                        n_pos      = '0;
                        n_rd_addr  = '0;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_rd_addr = r_rd_addr + 1'b1;
                end
                if (r_rd_vld) begin
                    if (r_rd_idx == r_pos) begin
                        n_first = rd_data;
                        n_best  = rd_data;
                        n_pick  = r_rd_idx;
                    end else if (better) begin
                        n_best = rd_data;
                        n_pick = r_rd_idx;
                    end
                    if (r_rd_idx == r_last_idx) begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                // move the displaced head word into the slot of the pick
                we                 = 1'b1;
                waddr              = r_pick;
                wdata              = r_first;
                n_strobe           = 1'b1;
                n_out.sorted_value = r_best;
                n_out.last_out     = (r_pos == r_last_idx);
                n_out.overflow     = r_drop;
                if (r_pos == r_last_idx) begin
                    n_count = '0;
                    n_drop  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_pos     = r_pos + 1'b1;
                    n_rd_addr = CW'(r_pos) + 1'b1;
                    n_state   = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_desc   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_rd_vld <= rd_en;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_desc <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_pos      <= n_pos;
        r_last_idx <= n_last_idx;
        r_rd_addr  <= n_rd_addr;
        r_rd_idx   <= r_rd_addr[AW-1:0];
        r_best     <= n_best;
        r_first    <= n_first;
        r_pick     <= n_pick;
        r_out      <= n_out;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ssud_mem.sv
// Element store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ssud_mem #(
    parameter int unsigned DEPTH = 64
) (
    input  wire                                  i_clk,
    input  wire                                  i_we,
    input  wire  [$clog2(DEPTH)-1:0]             i_waddr,
    input  wire  signed [ssud_pkg::DATA_W-1:0]   i_wdata,
    input  wire                                  i_re,
    input  wire  [$clog2(DEPTH)-1:0]             i_raddr,
    output logic signed [ssud_pkg::DATA_W-1:0]   o_rdata
);
    import ssud_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: sim/selection_sort_up_down_test.sv
// Testbench: random and directed lists through the up/down selection sorter, checked per word.
`timescale 1ns / 1ps
module selection_sort_up_down_test;
    import ssud_pkg::*;

    localparam int unsigned CAPACITY  = 64;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int unsigned RANDOM_WORDS = 270;

    class sort_scoreboard;
        logic signed [DATA_W-1:0] open_list[$];
        t_out_word sorted_due[$];
        bit        dropped    = 1'b0;
        bit        down_order = 1'b0;
        int        mismatches = 0;

        // Buffer one accepted word; a closing word sorts the list and queues its results.
        function void take_word(t_in_word w);
            logic signed [DATA_W-1:0] tmp;
            int        pick;
            t_out_word r;
            if (open_list.size() < CAPACITY) begin
                open_list.push_back(w.value);
            end else begin
                dropped = 1'b1;
            end
            if (w.last_in) begin
                for (int pos = 0; pos + 1 < open_list.size(); pos++) begin
                    pick = pos;
                    for (int k = pos + 1; k < open_list.size(); k++) begin
                        if (down_order ? (open_list[k] > open_list[pick])
                                       : (open_list[k] < open_list[pick])) begin
                            pick = k;
                        end
                    end
                    tmp             = open_list[pos];
                    open_list[pos]  = open_list[pick];
                    open_list[pick] = tmp;
                end
                for (int k = 0; k < open_list.size(); k++) begin
                    r.sorted_value = open_list[k];
                    r.last_out     = (k == open_list.size() - 1);
                    r.overflow     = dropped;
                    sorted_due.push_back(r);
                end
                open_list.delete();
                dropped = 1'b0;
            end
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (sorted_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected word value=%0d last=%0b ovf=%0b", $realtime,
                             got.sorted_value, got.last_out, got.overflow);
                end
            end else begin
                want = sorted_due.pop_front();
                if (got.sorted_value !== want.sorted_value || got.last_out !== want.last_out
                        || got.overflow !== want.overflow) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: word mismatch exp value=%0d last=%0b ovf=%0b",
                                 $realtime, want.sorted_value, want.last_out, want.overflow);
                        $display("%0t:               got value=%0d last=%0b ovf=%0b",
                                 $realtime, got.sorted_value, got.last_out, got.overflow);
                    end
                end
            end
        endfunction

        function void close_out();
            if (sorted_due.size() != 0) begin
                $display("%0d expected words never arrived", sorted_due.size());
                mismatches += sorted_due.size();
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      start       = 1'b0;
    t_in_word  i_in        = '0;
    logic      i_cfg_valid = 1'b0;
    logic      i_cfg_data  = 1'b0;
    logic      busy;
    logic      o_out_strobe;
    t_out_word o_out;
    logic      o_cfg_ready;

    sort_scoreboard sb;
    int unsigned    words_sent = 0;
    logic signed [DATA_W-1:0] fixed_list[$];

    selection_sort_up_down #(
        .MAX_ITEMS    (CAPACITY)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_in         (i_in),
        .o_out_strobe (o_out_strobe),
        .o_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_strobe) begin
            sb.check_word(o_out);
        end
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Present one word and hold start until the block takes it; start stays high afterwards.
    task automatic send_word(input logic signed [DATA_W-1:0] v, input bit last);
        t_in_word w;
        w.value   = v;
        w.last_in = last;
        i_in  <= w;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.take_word(w);
        words_sent++;
    endtask

    task automatic idle_sender();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold off until every expected word is out and the block has gone quiet.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.sorted_due.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_order(input bit down);
        i_cfg_data  <= down;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.down_order = down;
    endtask

    task automatic send_fixed();
        for (int k = 0; k < fixed_list.size(); k++) begin
            send_word(fixed_list[k], k == fixed_list.size() - 1);
            idle_sender();
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3: return $urandom;
            4, 5:       return $signed($urandom_range(0, 20)) - 10;
            6: begin
                case ($urandom_range(0, 5))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return VAL_MIN + 1;
                    3:       return VAL_MAX - 1;
                    4:       return -1;
                    default: return 0;
                endcase
            end
            default:    return $signed($urandom_range(0, 3)) * 1000 - 1500;
        endcase
    endfunction

    initial begin
        int  len;
        int  r;
        bit  steady;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single word, extremes and repeats in both orders
        set_order(1'b0);
        fixed_list = '{32'sd5};
        send_fixed();
        fixed_list = '{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MIN, VAL_MAX};
        send_fixed();
        drain();
        set_order(1'b1);
        send_fixed();
        fixed_list = '{32'sd3, 32'sd3, 32'sd3};
        send_fixed();
        fixed_list = '{VAL_MIN};
        send_fixed();
        drain();
        set_order(1'b0);
        fixed_list = '{-32'sd2, 32'sd7};
        send_fixed();

        // random lists; two of them fill the buffer, the second past capacity
        for (int lst = 0; words_sent < RANDOM_WORDS; lst++) begin
            r = $urandom_range(0, 99);
            if (lst == 5) begin
                len = CAPACITY;
            end else if (lst == 11) begin
                len = CAPACITY + 2 + $urandom_range(0, 4);
            end else if (r < 85) begin
                len = $urandom_range(1, 8);
            end else begin
                len = $urandom_range(9, 20);
            end
            if (lst == 3 || $urandom_range(0, 3) == 0) begin
                drain();
                set_order($urandom_range(0, 1));
            end
            steady = ($urandom_range(0, 9) < 3);
            for (int k = 0; k < len; k++) begin
                send_word(pick_value(), k == len - 1);
                if (!steady) begin
                    idle_sender();
                end
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        sb.close_out();
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
